>>> rtl/utf8s_pkg.sv
// Package for the UTF-8 sanitizer: payload structs, decoder result type,
// sequencer states and the replacement character bytes. No dependencies.
package utf8s_pkg;

    // Window of bytes under examination: held bytes plus the newest byte.
    localparam int WIN_DEPTH = 4;
    localparam int CNT_W     = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_last;
    } out_beat_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [WIN_DEPTH-1:0] win_t;

    typedef enum logic [1:0] {
        DEC_DONE,
        DEC_PASS,
        DEC_REPL,
        DEC_HOLD
    } dec_kind_t;

    typedef struct packed {
        dec_kind_t        kind;
        logic [CNT_W-1:0] len;
    } dec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // U+FFFD encoded as UTF-8.
    localparam byte_t REPL_BYTE0 = 8'hEF;
    localparam byte_t REPL_BYTE1 = 8'hBF;
    localparam byte_t REPL_BYTE2 = 8'hBD;

    localparam byte_t MASK_2 = 8'hE0;
    localparam byte_t LEAD_2 = 8'hC0;
    localparam byte_t MASK_3 = 8'hF0;
    localparam byte_t LEAD_3 = 8'hE0;
    localparam byte_t MASK_4 = 8'hF8;
    localparam byte_t LEAD_4 = 8'hF0;
    localparam byte_t ASCII_LIMIT = 8'h80;

endpackage

>>> rtl/utf8_sanitize_replace.sv
// UTF-8 sanitizer top level: sequencer, byte window and output register.
// Depends on utf8s_pkg, utf8s_decode and utf8s_shift.

// The block takes one raw byte per input beat and emits sanitized UTF-8, one
// byte per output beat. Well-formed sequences pass unchanged; a bad lead byte,
// a broken sequence or a sequence cut off by the end of the stream becomes
// EF BF BD and only the offending byte is dropped, after which the following
// bytes are examined again. Up to three bytes of an unfinished sequence are
// held between input beats. The last output beat caused by an input beat has
// run_last set, and on the input beat that carries in_last it also has
// stream_last set; an input beat may cause no output at all while a sequence
// is incomplete. An input beat produces up to 12 output bytes, from passed
// sequences and replacements. The sequence decoder at the head of the window
// looks at one sequence per scan cycle, and a final scan finds the window
// done or waiting; the output register moves one byte per cycle while the
// output is not stalled. The input side is stalled from acceptance until
// the window has been fully scanned; the last result byte may still sit in
// the output register when the next input beat is taken.
module utf8_sanitize_replace (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  utf8s_pkg::in_beat_t byte_data,
    output logic                text_valid,
    input  logic                text_stall,
    output utf8s_pkg::out_beat_t text_data
);
    import utf8s_pkg::*;

    state_t           state_reg, state_next;
    win_t             win_reg, win_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             last_reg, last_next;
    logic             repl_reg, repl_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             silent_reg, silent_next;
    out_beat_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    dec_t             cur_dec;
    dec_t             tail_dec;
    win_t             tail_win;
    logic [CNT_W-1:0] tail_n;

    logic             accept;
    logic             slot_free;
    logic             unit_end;
    byte_t            emit_byte;

    // The decoder examines the sequence at the head of the window. A second
    // copy looks at what follows it, so that the last byte of a step can be
    // flagged when it is emitted.
    utf8s_decode u_cur_dec (
        .win   (win_reg),
        .count (n_reg),
        .last  (last_reg),
        .dec   (cur_dec)
    );

    utf8s_shift u_tail_shift (
        .win       (win_reg),
        .count     (n_reg),
        .amount    (cur_dec.len),
        .win_out   (tail_win),
        .count_out (tail_n)
    );

    utf8s_decode u_tail_dec (
        .win   (tail_win),
        .count (tail_n),
        .last  (last_reg),
        .dec   (tail_dec)
    );

    assign byte_stall = (state_reg != ST_IDLE);
    assign accept     = byte_valid && !byte_stall;
    assign slot_free  = !out_valid_reg || !text_stall;
    assign unit_end   = (idx_reg == len_reg - CNT_W'(1));

    assign text_valid = out_valid_reg;
    assign text_data  = out_reg;

    always_comb
    begin
        if (repl_reg)
        begin
            case (idx_reg)
                CNT_W'(0): emit_byte = REPL_BYTE0;
                CNT_W'(1): emit_byte = REPL_BYTE1;
                default:   emit_byte = REPL_BYTE2;
            endcase
        end
        else
        begin
            emit_byte = win_reg[0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cur_dec.kind == DEC_PASS || cur_dec.kind == DEC_REPL)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (slot_free && unit_end)
                    state_next = ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Window, emit counters and output register.
    always_comb
    begin
        win_next       = win_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        repl_next      = repl_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        silent_next    = silent_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && text_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Held bytes stay at the head; the new byte goes after them.
                    win_next[n_reg[1:0]] = byte_data.in_byte;
                    n_next               = n_reg + CNT_W'(1);
                    last_next            = byte_data.in_last;
                end
            end
            ST_SCAN:
            begin
                repl_next   = (cur_dec.kind == DEC_REPL);
                len_next    = (cur_dec.kind == DEC_REPL) ? CNT_W'(3) : cur_dec.len;
                idx_next    = '0;
                silent_next = (tail_dec.kind == DEC_DONE) || (tail_dec.kind == DEC_HOLD);
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.out_byte    = emit_byte;
                    out_next.run_last    = unit_end && silent_reg;
                    out_next.stream_last = unit_end && silent_reg && last_reg;
                    out_valid_next       = 1'b1;
                    idx_next             = idx_reg + CNT_W'(1);
                    // A passed byte leaves the window as it goes out; a
                    // replaced lead byte leaves with the last replacement byte.
                    if (!repl_reg || unit_end)
                    begin
                        for (int i = 0; i < WIN_DEPTH - 1; i++)
                            win_next[i] = win_reg[i+1];
                        win_next[WIN_DEPTH-1] = '0;
                        n_next = n_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                win_next = win_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        repl_reg   <= repl_next;
        len_reg    <= len_next;
        idx_reg    <= idx_next;
        silent_reg <= silent_next;
        out_reg    <= out_next;
    end

    // After a step that ends a stream nothing may stay held.
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && last_reg) |-> (n_reg == '0))
        else $error("bytes still held after end of stream");

    // At most three bytes are ever held while waiting for input.
    a_held_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (n_reg <= CNT_W'(3)))
        else $error("held byte count out of range");

    // A stream end marker only appears on the closing beat of a step.
    a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && text_data.stream_last) |-> text_data.run_last)
        else $error("stream_last without run_last");

    // A passed sequence is emitted only while its bytes are in the window.
    a_emit_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !repl_reg) |-> (n_reg != '0))
        else $error("emitting from an empty window");

endmodule

>>> rtl/utf8s_decode.sv
// Sequence decoder: classifies the sequence that starts at the head of a
// byte window. Depends on utf8s_pkg.
module utf8s_decode (
    input  utf8s_pkg::win_t            win,
    input  logic [utf8s_pkg::CNT_W-1:0] count,
    input  logic                       last,
    output utf8s_pkg::dec_t            dec
);
    import utf8s_pkg::*;

    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] lim;
    logic             ok;

    always_comb
    begin
        if (win[0] < ASCII_LIMIT)
            need = CNT_W'(1);
        else if ((win[0] & MASK_2) == LEAD_2)
            need = CNT_W'(2);
        else if ((win[0] & MASK_3) == LEAD_3)
            need = CNT_W'(3);
        else if ((win[0] & MASK_4) == LEAD_4)
            need = CNT_W'(4);
        else
            need = '0;
    end

    always_comb
    begin
        lim = (count < need) ? count : need;
        ok  = 1'b1;
        for (int i = 1; i < WIN_DEPTH; i++)
        begin
            if ((CNT_W'(i) < lim) && (win[i][7:6] != 2'b10))
                ok = 1'b0;
        end
    end

    always_comb
    begin
        dec.len = CNT_W'(1);
        if (count == '0)
            dec.kind = DEC_DONE;
        else if (need == CNT_W'(1))
            dec.kind = DEC_PASS;
        else if (need == '0 || !ok)
            dec.kind = DEC_REPL;
        else if (count >= need)
        begin
            dec.kind = DEC_PASS;
            dec.len  = need;
        end
        else if (last)
            dec.kind = DEC_REPL;
        else
            dec.kind = DEC_HOLD;
    end

endmodule

>>> rtl/utf8s_sanitize_top_placeholder.sv
// Byte window shifter: drops a number of bytes from the head of a window.
// Used to look at the sequence that follows the one being emitted.
// Depends on utf8s_pkg.
module utf8s_shift (
    input  utf8s_pkg::win_t             win,
    input  logic [utf8s_pkg::CNT_W-1:0] count,
    input  logic [utf8s_pkg::CNT_W-1:0] amount,
    output utf8s_pkg::win_t             win_out,
    output logic [utf8s_pkg::CNT_W-1:0] count_out
);
    import utf8s_pkg::*;

    logic [CNT_W-1:0] src;

    always_comb
    begin
        win_out = '0;
        src     = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            src = CNT_W'(i) + amount;
            if (src < CNT_W'(WIN_DEPTH))
                win_out[i] = win[src[1:0]];
        end
        count_out = (count > amount) ? (count - amount) : '0;
    end

endmodule
